// File: sv/llp_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// llp_pkg
// Shared codes and types for the linked list pool with minimum query.
// ----------------------------------------------------------------------------
package llp_pkg;

    // Field widths of one input item and one result item.
    localparam int OP_W     = 2;
    localparam int ID_W     = 24;
    localparam int GRADE_W  = 10;
    localparam int SLOT_W   = 4;
    localparam int STATUS_W = 2;

    // Packed payload widths, padded to whole bytes.
    localparam int IN_DATA_W  = 40;
    localparam int OUT_DATA_W = 48;

    // Operation codes.
    localparam logic [OP_W-1:0] OP_INSERT = 2'd0;
    localparam logic [OP_W-1:0] OP_WALK   = 2'd1;
    localparam logic [OP_W-1:0] OP_FIND   = 2'd2;

    // Result status codes.
    localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
    localparam logic [STATUS_W-1:0] ST_FULL  = 2'd1;
    localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd2;

    // Commands from the controller to the datapath.
    typedef enum logic [3:0] {
        CMD_NONE,
        CMD_INIT,
        CMD_LOAD,
        CMD_INS_RD_FREE,
        CMD_INS_WR_NODE,
        CMD_INS_LINK_HEAD,
        CMD_INS_LINK_AFT1,
        CMD_INS_LINK_AFT2,
        CMD_RD_NODE,
        CMD_FIND_STEP,
        CMD_TIE_RD,
        CMD_EMIT_INS,
        CMD_EMIT_FULL,
        CMD_EMIT_EMPTY,
        CMD_EMIT_NODE,
        CMD_EMIT_TIE
    } dp_cmd_t;

    // Status flags from the datapath to the controller.
    typedef struct packed {
        logic init_last;
        logic free_nil;
        logic list_nil;
        logic after_ok;
        logic walk_last;
        logic tie_zero;
        logic out_free;
    } dp_status_t;

endpackage

// File: sv/llp_datapath.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// llp_datapath
// Node, link and tie memories, list pointers, walk registers and the
// result register, all driven by controller commands.
// ----------------------------------------------------------------------------
module llp_datapath
    import llp_pkg::*;
#(
    parameter int POOL_NODES = 16
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  dp_cmd_t             cmd,
    input  logic [OP_W-1:0]     in_op,
    input  logic [ID_W-1:0]     in_id,
    input  logic [GRADE_W-1:0]  in_grade,
    input  logic                in_after_valid,
    input  logic [SLOT_W-1:0]   in_after_slot,
    output dp_status_t          sts,
    output logic                out_valid,
    input  logic                out_ready,
    output logic [STATUS_W-1:0] out_status,
    output logic [SLOT_W-1:0]   out_slot,
    output logic [ID_W-1:0]     out_id,
    output logic [GRADE_W-1:0]  out_grade,
    output logic                out_next_valid,
    output logic [SLOT_W-1:0]   out_next_slot,
    output logic                out_last
);

    localparam int IW = $clog2(POOL_NODES);
    localparam int LW = $clog2(POOL_NODES + 1);
    localparam logic [LW-1:0] NIL = LW'(POOL_NODES);
    localparam logic [IW-1:0] LAST_IDX = IW'(POOL_NODES - 1);

    logic [ID_W-1:0]    ids_mem    [POOL_NODES];
    logic [GRADE_W-1:0] grades_mem [POOL_NODES];
    logic [LW-1:0]      links_mem  [POOL_NODES];
    logic [ID_W-1:0]    tie_mem    [POOL_NODES];

    logic [ID_W-1:0]    ids_rd_reg;
    logic [GRADE_W-1:0] grades_rd_reg;
    logic [LW-1:0]      links_rd_reg;
    logic [ID_W-1:0]    tie_rd_reg;

    logic [IW-1:0]      init_cnt_reg;
    logic [LW-1:0]      free_head_reg;
    logic [LW-1:0]      list_head_reg;
    logic [LW-1:0]      cnt_reg;
    logic               out_valid_reg;

    logic [IW-1:0]      cur_reg;
    logic [IW-1:0]      steps_reg;
    logic               first_reg;
    logic [GRADE_W-1:0] minv_reg;
    logic [ID_W-1:0]    id_reg;
    logic [GRADE_W-1:0] grade_reg;
    logic               after_ok_reg;
    logic [IW-1:0]      after_idx_reg;

    logic               links_we;
    logic [IW-1:0]      links_wa;
    logic [LW-1:0]      links_wd;
    logic               links_re;
    logic [IW-1:0]      links_ra;
    logic               tie_we;
    logic [IW-1:0]      tie_wa;
    logic               has_next;
    logic               new_min;
    logic               same_min;
    logic               emit;

    assign has_next = links_rd_reg < NIL;
    assign new_min  = first_reg || (grades_rd_reg < minv_reg);
    assign same_min = grades_rd_reg == minv_reg;
    assign emit     = (cmd == CMD_EMIT_INS) || (cmd == CMD_EMIT_FULL) ||
                      (cmd == CMD_EMIT_EMPTY) || (cmd == CMD_EMIT_NODE) ||
                      (cmd == CMD_EMIT_TIE);

    assign sts.init_last = init_cnt_reg == LAST_IDX;
    assign sts.free_nil  = free_head_reg >= NIL;
    assign sts.list_nil  = list_head_reg >= NIL;
    assign sts.after_ok  = after_ok_reg;
    assign sts.walk_last = !has_next || (steps_reg == LAST_IDX);
    assign sts.tie_zero  = cnt_reg == '0;
    assign sts.out_free  = !out_valid_reg || out_ready;

    assign out_valid = out_valid_reg;

    // Link memory port selection.
    always_comb
    begin
        links_we = 1'b0;
        links_wa = '0;
        links_wd = '0;
        links_re = 1'b0;
        links_ra = '0;
        unique case (cmd)
            CMD_INIT:
            begin
                links_we = 1'b1;
                links_wa = init_cnt_reg;
                links_wd = LW'(init_cnt_reg) + LW'(1);
            end
            CMD_INS_RD_FREE, CMD_RD_NODE:
            begin
                links_re = 1'b1;
                links_ra = cur_reg;
            end
            CMD_INS_WR_NODE:
            begin
                links_re = 1'b1;
                links_ra = after_idx_reg;
            end
            CMD_INS_LINK_HEAD:
            begin
                links_we = 1'b1;
                links_wa = cur_reg;
                links_wd = list_head_reg;
            end
            CMD_INS_LINK_AFT1:
            begin
                links_we = 1'b1;
                links_wa = cur_reg;
                links_wd = links_rd_reg;
            end
            CMD_INS_LINK_AFT2:
            begin
                links_we = 1'b1;
                links_wa = after_idx_reg;
                links_wd = LW'(cur_reg);
            end
            default:
            begin
            end
        endcase
    end

    // A lower grade restarts the tie list at entry zero.
    always_comb
    begin
        tie_we = (cmd == CMD_FIND_STEP) && (new_min || same_min);
        tie_wa = new_min ? '0 : IW'(cnt_reg);
    end

    always_ff @(posedge clk)
    begin
        if (links_we)
        begin
            links_mem[links_wa] <= links_wd;
        end
        if (links_re)
        begin
            links_rd_reg <= links_mem[links_ra];
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd == CMD_INS_WR_NODE)
        begin
            ids_mem[cur_reg]    <= id_reg;
            grades_mem[cur_reg] <= grade_reg;
        end
        if (cmd == CMD_RD_NODE)
        begin
            ids_rd_reg    <= ids_mem[cur_reg];
            grades_rd_reg <= grades_mem[cur_reg];
        end
    end

    always_ff @(posedge clk)
    begin
        if (tie_we)
        begin
            tie_mem[tie_wa] <= ids_rd_reg;
        end
        if (cmd == CMD_TIE_RD)
        begin
            tie_rd_reg <= tie_mem[IW'(cnt_reg - LW'(1))];
        end
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            init_cnt_reg  <= '0;
            free_head_reg <= '0;
            list_head_reg <= NIL;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cmd == CMD_INIT)
            begin
                init_cnt_reg <= init_cnt_reg + IW'(1);
            end
            if (cmd == CMD_INS_WR_NODE)
            begin
                free_head_reg <= links_rd_reg;
            end
            if (cmd == CMD_INS_LINK_HEAD)
            begin
                list_head_reg <= LW'(cur_reg);
            end
            if ((cmd == CMD_LOAD) && (in_op == OP_FIND))
            begin
                cnt_reg <= '0;
            end
            else if (tie_we)
            begin
                cnt_reg <= new_min ? LW'(1) : cnt_reg + LW'(1);
            end
            else if (cmd == CMD_TIE_RD)
            begin
                cnt_reg <= cnt_reg - LW'(1);
            end
            if (emit)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Working registers of the current item.
    always_ff @(posedge clk)
    begin
        unique case (cmd)
            CMD_LOAD:
            begin
                cur_reg       <= (in_op == OP_INSERT) ? IW'(free_head_reg)
                                                      : IW'(list_head_reg);
                steps_reg     <= '0;
                first_reg     <= 1'b1;
                id_reg        <= in_id;
                grade_reg     <= in_grade;
                after_ok_reg  <= in_after_valid && (32'(in_after_slot) < POOL_NODES);
                after_idx_reg <= IW'(in_after_slot);
            end
            CMD_EMIT_NODE:
            begin
                cur_reg   <= IW'(links_rd_reg);
                steps_reg <= steps_reg + IW'(1);
            end
            CMD_FIND_STEP:
            begin
                cur_reg   <= IW'(links_rd_reg);
                steps_reg <= steps_reg + IW'(1);
                first_reg <= 1'b0;
                if (new_min)
                begin
                    minv_reg <= grades_rd_reg;
                end
            end
            default:
            begin
            end
        endcase
    end

    // Result register.
    always_ff @(posedge clk)
    begin
        if (emit)
        begin
            out_status     <= ST_OK;
            out_slot       <= '0;
            out_id         <= '0;
            out_grade      <= '0;
            out_next_valid <= 1'b0;
            out_next_slot  <= '0;
            out_last       <= 1'b1;
            unique case (cmd)
                CMD_EMIT_INS:
                begin
                    out_slot <= SLOT_W'(cur_reg);
                end
                CMD_EMIT_FULL:
                begin
                    out_status <= ST_FULL;
                end
                CMD_EMIT_EMPTY:
                begin
                    out_status <= ST_EMPTY;
                end
                CMD_EMIT_NODE:
                begin
                    out_slot       <= SLOT_W'(cur_reg);
                    out_id         <= ids_rd_reg;
                    out_grade      <= grades_rd_reg;
                    out_next_valid <= has_next;
                    out_next_slot  <= has_next ? SLOT_W'(links_rd_reg) : '0;
                    out_last       <= sts.walk_last;
                end
                CMD_EMIT_TIE:
                begin
                    out_id    <= tie_rd_reg;
                    out_grade <= minv_reg;
                    out_last  <= cnt_reg == '0;
                end
                default:
                begin
                end
            endcase
        end
    end

    a_emit_needs_room: assert property (@(posedge clk) disable iff (!rst_n)
        emit |-> (!out_valid_reg || out_ready))
        else $error("result loaded over a stalled result");

    a_tie_read_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd == CMD_TIE_RD) |-> (cnt_reg != '0))
        else $error("tie read with an empty tie list");

    a_heads_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        (free_head_reg <= NIL) && (list_head_reg <= NIL) && (cnt_reg <= NIL))
        else $error("list pointer or tie count out of range");

endmodule

// File: sv/llp_controller.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// llp_controller
// Sequencer that steps the datapath through clearing, insert, walk and
// find-minimum operations.
// ----------------------------------------------------------------------------
module llp_controller
    import llp_pkg::*;
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic            in_valid,
    output logic            in_ready,
    input  logic [OP_W-1:0] in_op,
    input  dp_status_t      sts,
    output dp_cmd_t         cmd
);

    typedef enum logic [3:0] {
        S_INIT,
        S_IDLE,
        S_INS_RD,
        S_INS_WR,
        S_INS_HEAD,
        S_INS_AFT1,
        S_INS_AFT2,
        S_EMIT_INS,
        S_EMIT_FULL,
        S_EMIT_EMPTY,
        S_WALK_RD,
        S_WALK_EMIT,
        S_FIND_RD,
        S_FIND_STEP,
        S_TIE_RD,
        S_TIE_EMIT
    } state_t;

    state_t state_reg;
    state_t state_next;

    assign in_ready = state_reg == S_IDLE;

    always_comb
    begin
        state_next = state_reg;
        cmd        = CMD_NONE;
        unique case (state_reg)
            S_INIT:
            begin
                cmd = CMD_INIT;
                if (sts.init_last)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd = CMD_LOAD;
                    priority if (in_op == OP_INSERT)
                    begin
                        state_next = sts.free_nil ? S_EMIT_FULL : S_INS_RD;
                    end
                    else if (in_op == OP_WALK)
                    begin
                        state_next = sts.list_nil ? S_EMIT_EMPTY : S_WALK_RD;
                    end
                    else if (in_op == OP_FIND)
                    begin
                        state_next = sts.list_nil ? S_EMIT_EMPTY : S_FIND_RD;
                    end
                    else
                    begin
                        state_next = S_IDLE;
                    end
                end
            end
            S_INS_RD:
            begin
                cmd        = CMD_INS_RD_FREE;
                state_next = S_INS_WR;
            end
            S_INS_WR:
            begin
                cmd        = CMD_INS_WR_NODE;
                state_next = sts.after_ok ? S_INS_AFT1 : S_INS_HEAD;
            end
            S_INS_HEAD:
            begin
                cmd        = CMD_INS_LINK_HEAD;
                state_next = S_EMIT_INS;
            end
            S_INS_AFT1:
            begin
                cmd        = CMD_INS_LINK_AFT1;
                state_next = S_INS_AFT2;
            end
            S_INS_AFT2:
            begin
                cmd        = CMD_INS_LINK_AFT2;
                state_next = S_EMIT_INS;
            end
            S_EMIT_INS:
            begin
                if (sts.out_free)
                begin
                    cmd        = CMD_EMIT_INS;
                    state_next = S_IDLE;
                end
            end
            S_EMIT_FULL:
            begin
                if (sts.out_free)
                begin
                    cmd        = CMD_EMIT_FULL;
                    state_next = S_IDLE;
                end
            end
            S_EMIT_EMPTY:
            begin
                if (sts.out_free)
                begin
                    cmd        = CMD_EMIT_EMPTY;
                    state_next = S_IDLE;
                end
            end
            S_WALK_RD:
            begin
                cmd        = CMD_RD_NODE;
                state_next = S_WALK_EMIT;
            end
            S_WALK_EMIT:
            begin
                if (sts.out_free)
                begin
                    cmd        = CMD_EMIT_NODE;
                    state_next = sts.walk_last ? S_IDLE : S_WALK_RD;
                end
            end
            S_FIND_RD:
            begin
                cmd        = CMD_RD_NODE;
                state_next = S_FIND_STEP;
            end
            S_FIND_STEP:
            begin
                cmd        = CMD_FIND_STEP;
                state_next = sts.walk_last ? S_TIE_RD : S_FIND_RD;
            end
            S_TIE_RD:
            begin
                cmd        = CMD_TIE_RD;
                state_next = S_TIE_EMIT;
            end
            S_TIE_EMIT:
            begin
                if (sts.out_free)
                begin
                    cmd        = CMD_EMIT_TIE;
                    state_next = sts.tie_zero ? S_IDLE : S_TIE_RD;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_INIT;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    a_init_once: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != S_INIT) |=> (state_reg != S_INIT))
        else $error("link clearing pass restarted outside reset");

endmodule

// File: sv/linked_list_pool_with_min_query_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// linked_list_pool_with_min_query_top
// Pool of linked nodes with a free chain, supporting insert, in-order walk
// and a query for the ids that share the lowest grade.
// ----------------------------------------------------------------------------
// After reset the block runs a clearing pass that chains every slot into
// the free chain; s_tready stays low until it is done. Each input transfer
// carries one operation in s_tuser. s_tready is high only while the
// sequencer is idle, so no new operation is taken until the last result of
// the current one is loaded into the output register. The free link has to
// be read back before the free head can move, and linking after a slot
// needs a second registered read and two writes on the single port pair of
// the link memory. A walk or a find-minimum visits each node with one
// registered read of the link memory followed by the step that uses it, and
// a find-minimum reads each tied id back from the tie memory the same way.
// Results go through an output register, so a new operation is accepted
// while the last result of the previous one waits; a stalled m_tready
// simply holds the sequencer at its next emit.
// ----------------------------------------------------------------------------
module linked_list_pool_with_min_query_top
    import llp_pkg::*;
#(
    parameter int POOL_NODES = 16
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    // s_tdata, from bit 0: student_id[23:0], grade_tenths[33:24],
    // after_valid[34], after_slot[38:35], zero pad[39].
    input  logic [IN_DATA_W-1:0]  s_tdata,
    // s_tuser, from bit 0: op[1:0].
    input  logic [OP_W-1:0]       s_tuser,
    output logic                  m_tvalid,
    input  logic                  m_tready,
    // m_tdata, from bit 0: status[1:0], slot[5:2], out_id[29:6],
    // out_grade[39:30], next_valid[40], next_slot[44:41], zero pad[47:45].
    output logic [OUT_DATA_W-1:0] m_tdata,
    output logic                  m_tlast
);

    dp_cmd_t             cmd;
    dp_status_t          sts;
    logic [STATUS_W-1:0] out_status;
    logic [SLOT_W-1:0]   out_slot;
    logic [ID_W-1:0]     out_id;
    logic [GRADE_W-1:0]  out_grade;
    logic                out_next_valid;
    logic [SLOT_W-1:0]   out_next_slot;

    // The controller owns the sequencing; the datapath owns every memory
    // and pointer and answers with a small set of status flags.
    llp_controller u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_tvalid),
        .in_ready (s_tready),
        .in_op    (s_tuser),
        .sts      (sts),
        .cmd      (cmd)
    );

    llp_datapath #(
        .POOL_NODES (POOL_NODES)
    ) u_dp (
        .clk            (clk),
        .rst_n          (rst_n),
        .cmd            (cmd),
        .in_op          (s_tuser),
        .in_id          (s_tdata[23:0]),
        .in_grade       (s_tdata[33:24]),
        .in_after_valid (s_tdata[34]),
        .in_after_slot  (s_tdata[38:35]),
        .sts            (sts),
        .out_valid      (m_tvalid),
        .out_ready      (m_tready),
        .out_status     (out_status),
        .out_slot       (out_slot),
        .out_id         (out_id),
        .out_grade      (out_grade),
        .out_next_valid (out_next_valid),
        .out_next_slot  (out_next_slot),
        .out_last       (m_tlast)
    );

    // Pack the result fields, first field in the lowest bits.
    assign m_tdata = {3'b000, out_next_slot, out_next_valid, out_grade,
                      out_id, out_slot, out_status};

endmodule

// File: tb/linked_list_pool_with_min_query_top_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// linked_list_pool_with_min_query_top_tb
// Self-checking bench for the linked node pool with minimum-grade query.
// ----------------------------------------------------------------------------
// A scoreboard keeps its own copy of the pool (ids, grades, links, free chain
// and list head). Every accepted input transfer is applied to that copy and
// the results it must produce are queued. Every output transfer is compared
// field by field with the oldest queued result. Stimulus runs through a short
// directed pass, a phase where the receiver holds off for a long stretch, and
// a long random mix. The sender idles in random bursts and the receiver
// follows a changing stall pattern.
// ----------------------------------------------------------------------------
module linked_list_pool_with_min_query_top_tb;
    import llp_pkg::*;

    localparam int NODES        = 16;
    localparam int LINK_W       = 5;
    localparam int ITEM_TOTAL   = 310;
    localparam int DRAIN_CYCLES = 100;
    localparam int HOLD_CYCLES  = 400;
    localparam int TIMEOUT_NS   = 2_000_000;
    localparam int PRINT_CAP    = 50;

    // The op field has one code the block does not implement; it must be
    // ignored without any result.
    localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;

    // One result transfer, unpacked into its fields.
    typedef struct {
        logic [STATUS_W-1:0] status;
        logic [SLOT_W-1:0]   slot;
        logic [ID_W-1:0]     id;
        logic [GRADE_W-1:0]  grade;
        logic                next_valid;
        logic [SLOT_W-1:0]   next_slot;
        logic                is_last;
    } pool_result_t;

    logic                  clk;
    logic                  rst_n;
    logic                  s_tvalid;
    logic                  s_tready;
    logic [IN_DATA_W-1:0]  s_tdata;
    logic [OP_W-1:0]       s_tuser;
    logic                  m_tvalid;
    logic                  m_tready;
    logic [OUT_DATA_W-1:0] m_tdata;
    logic                  m_tlast;

    // Scoreboard copy of the pool. A link value of NODES marks the end of a
    // chain. pool_written tracks which slots have ever been filled, so that
    // insert-after targets can favor real list members.
    logic [ID_W-1:0]    pool_id      [NODES];
    logic [GRADE_W-1:0] pool_grade   [NODES];
    logic [LINK_W-1:0]  pool_link    [NODES];
    logic [NODES-1:0]   pool_written;
    logic [LINK_W-1:0]  free_ptr;
    logic [LINK_W-1:0]  head_ptr;

    // Results still owed by the block, oldest first.
    pool_result_t awaited_results[$];

    int mismatch_count  = 0;
    int valid_ops_sent  = 0;
    int burst_left      = 0;
    int rx_hold_request = 0;

    linked_list_pool_with_min_query_top #(
        .POOL_NODES (NODES)
    ) dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

    always
    begin
        clk = 1'b0;
        #2;
        clk = 1'b1;
        #2;
    end

    // ------------------------------------------------------------------------
    // Scoreboard model
    // ------------------------------------------------------------------------

    function automatic void pool_reset();
        for (int i = 0; i < NODES; i++)
        begin
            pool_link[i]  = LINK_W'(i + 1);
            pool_id[i]    = '0;
            pool_grade[i] = '0;
        end
        pool_written = '0;
        free_ptr     = '0;
        head_ptr     = LINK_W'(NODES);
    endfunction

    function automatic void await_result(logic [STATUS_W-1:0] status,
                                         logic [SLOT_W-1:0] slot,
                                         logic [ID_W-1:0] id,
                                         logic [GRADE_W-1:0] grade,
                                         logic next_valid,
                                         logic [SLOT_W-1:0] next_slot,
                                         logic is_last);
        pool_result_t r;
        r.status     = status;
        r.slot       = slot;
        r.id         = id;
        r.grade      = grade;
        r.next_valid = next_valid;
        r.next_slot  = next_slot;
        r.is_last    = is_last;
        awaited_results.push_back(r);
    endfunction

    // Applies one accepted operation to the scoreboard pool and queues the
    // results that the block has to return for it.
    function automatic void apply_pool_op(logic [OP_W-1:0] op,
                                          logic [ID_W-1:0] id,
                                          logic [GRADE_W-1:0] grade,
                                          logic after_valid,
                                          logic [SLOT_W-1:0] after_slot);
        logic [LINK_W-1:0]  cur;
        logic [LINK_W-1:0]  nx;
        logic [LINK_W-1:0]  taken;
        logic [GRADE_W-1:0] low_grade;
        logic [ID_W-1:0]    tie_buf [NODES];
        logic               has_next;
        int                 tie_n;
        int                 steps;

        case (op)
            OP_INSERT:
            begin
                if (free_ptr >= NODES)
                begin
                    await_result(ST_FULL, '0, '0, '0, 1'b0, '0, 1'b1);
                end
                else
                begin
                    taken               = free_ptr;
                    free_ptr            = pool_link[taken];
                    pool_id[taken]      = id;
                    pool_grade[taken]   = grade;
                    pool_written[taken] = 1'b1;
                    // The target slot is linked blindly, whether or not it is
                    // on the list; a self target detaches the new node.
                    if (after_valid && after_slot < NODES)
                    begin
                        pool_link[taken]      = pool_link[after_slot];
                        pool_link[after_slot] = taken;
                    end
                    else
                    begin
                        pool_link[taken] = head_ptr;
                        head_ptr         = taken;
                    end
                    await_result(ST_OK, taken[SLOT_W-1:0], '0, '0, 1'b0, '0, 1'b1);
                end
            end
            OP_WALK:
            begin
                if (head_ptr >= NODES)
                begin
                    await_result(ST_EMPTY, '0, '0, '0, 1'b0, '0, 1'b1);
                end
                else
                begin
                    cur = head_ptr;
                    for (steps = 0; steps < NODES && cur < NODES; steps++)
                    begin
                        nx       = pool_link[cur];
                        has_next = nx < NODES;
                        await_result(ST_OK, cur[SLOT_W-1:0], pool_id[cur], pool_grade[cur],
                                     has_next, has_next ? nx[SLOT_W-1:0] : '0,
                                     !has_next || (steps + 1 == NODES));
                        cur = nx;
                    end
                end
            end
            OP_FIND:
            begin
                tie_n = 0;
                if (head_ptr >= NODES)
                begin
                    await_result(ST_EMPTY, '0, '0, '0, 1'b0, '0, 1'b1);
                end
                else
                begin
                    cur       = head_ptr;
                    low_grade = pool_grade[cur];
                    for (steps = 0; steps < NODES && cur < NODES; steps++)
                    begin
                        // A strictly lower grade throws away the ties so far.
                        if (pool_grade[cur] < low_grade)
                        begin
                            tie_n     = 0;
                            low_grade = pool_grade[cur];
                        end
                        if (pool_grade[cur] == low_grade && tie_n < NODES)
                        begin
                            tie_buf[tie_n] = pool_id[cur];
                            tie_n++;
                        end
                        cur = pool_link[cur];
                    end
                    // Ties come back newest first.
                    for (int k = tie_n - 1; k >= 0; k--)
                    begin
                        await_result(ST_OK, '0, tie_buf[k], low_grade, 1'b0, '0, k == 0);
                    end
                end
            end
            default:
            begin
            end
        endcase
    endfunction

    // ------------------------------------------------------------------------
    // Checking
    // ------------------------------------------------------------------------

    // Prints one line per mismatch. Past PRINT_CAP the mismatches are only
    // counted, which keeps the log readable when the block is badly off.
    task automatic report_mismatch(input string what,
                                   input logic [OUT_DATA_W-1:0] got,
                                   input logic [OUT_DATA_W-1:0] want);
        if (mismatch_count < PRINT_CAP)
        begin
            $display("%0t ns: MISMATCH %s: got 0x%0h, expected 0x%0h",
                     $realtime, what, got, want);
        end
        mismatch_count++;
    endtask

    // Every output transfer is checked against the oldest awaited result.
    always @(posedge clk)
    begin
        pool_result_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            if (awaited_results.size() == 0)
            begin
                report_mismatch("result with nothing awaited", m_tdata, '0);
            end
            else
            begin
                want = awaited_results.pop_front();
                if (m_tdata[1:0] !== want.status)
                    report_mismatch("status", m_tdata[1:0], want.status);
                if (m_tdata[5:2] !== want.slot)
                    report_mismatch("slot", m_tdata[5:2], want.slot);
                if (m_tdata[29:6] !== want.id)
                    report_mismatch("out_id", m_tdata[29:6], want.id);
                if (m_tdata[39:30] !== want.grade)
                    report_mismatch("out_grade", m_tdata[39:30], want.grade);
                if (m_tdata[40] !== want.next_valid)
                    report_mismatch("next_valid", m_tdata[40], want.next_valid);
                if (m_tdata[44:41] !== want.next_slot)
                    report_mismatch("next_slot", m_tdata[44:41], want.next_slot);
                if (m_tlast !== want.is_last)
                    report_mismatch("tlast", m_tlast, want.is_last);
            end
        end
    end

    // ------------------------------------------------------------------------
    // Receiver
    // ------------------------------------------------------------------------

    // The receiver switches between stall patterns, each picked at random:
    // always ready, coin flip, mostly stalled, and a fixed 3-of-7 duty.
    // A hold request from a test forces a long stretch of stall, counted here.
    initial
    begin : receiver
        int cyc;
        int hold_left;
        int mode;
        cyc       = 0;
        hold_left = 0;
        mode      = 0;
        m_tready <= 1'b0;
        forever
        begin
            @(posedge clk);
            cyc++;
            if (rx_hold_request > 0)
            begin
                hold_left       = rx_hold_request;
                rx_hold_request = 0;
            end
            if (cyc % 100 == 0)
                mode = $urandom_range(0, 3);
            if (hold_left > 0)
            begin
                hold_left--;
                m_tready <= 1'b0;
            end
            else
            begin
                case (mode)
                    0:       m_tready <= 1'b1;
                    1:       m_tready <= 1'($urandom_range(0, 1));
                    2:       m_tready <= ($urandom_range(0, 3) == 0);
                    default: m_tready <= (cyc % 7) < 3;
                endcase
            end
        end
    end

    // ------------------------------------------------------------------------
    // Sender
    // ------------------------------------------------------------------------

    // Offers one operation and returns at the clock edge of its transfer,
    // where the scoreboard is updated. Transfers go out in bursts of random
    // length; a random gap with tvalid low may open before each burst.
    task automatic send_op(input logic [OP_W-1:0] op,
                           input logic [ID_W-1:0] id,
                           input logic [GRADE_W-1:0] grade,
                           input logic after_valid,
                           input logic [SLOT_W-1:0] after_slot);
        int gap;
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 12);
            gap        = ($urandom_range(0, 4) == 0) ? $urandom_range(5, 20)
                                                      : $urandom_range(0, 3);
            if (gap > 0)
            begin
                s_tvalid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        burst_left--;
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= {1'b0, after_slot, after_valid, grade, id};
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        apply_pool_op(op, id, grade, after_valid, after_slot);
        if (op != OP_UNUSED)
            valid_ops_sent++;
    endtask

    // Grades are drawn from a narrow set most of the time so that ties at
    // the minimum are common.
    function automatic logic [GRADE_W-1:0] rand_grade();
        case ($urandom_range(0, 5))
            0:       return '0;
            1:       return '1;
            2, 3:    return GRADE_W'(500 + $urandom_range(0, 2));
            default: return GRADE_W'($urandom_range(0, 1023));
        endcase
    endfunction

    // Mostly a slot that already holds a node; now and then any slot, which
    // may sit on the free chain and so bends the chains.
    function automatic logic [SLOT_W-1:0] pick_after_slot();
        logic [SLOT_W-1:0] s;
        int                tries;
        s = SLOT_W'($urandom_range(0, NODES - 1));
        if ($urandom_range(0, 4) != 0)
        begin
            for (tries = 0; tries < 32 && !pool_written[s]; tries++)
                s = SLOT_W'($urandom_range(0, NODES - 1));
        end
        return s;
    endfunction

    task automatic send_random_insert();
        send_op(OP_INSERT, ID_W'($urandom), rand_grade(), 1'($urandom_range(0, 1)),
                pick_after_slot());
    endtask

    // Walk, find and unused codes ignore the data fields; they carry noise.
    task automatic send_noise_op(input logic [OP_W-1:0] op);
        send_op(op, ID_W'($urandom), GRADE_W'($urandom), 1'($urandom), SLOT_W'($urandom));
    endtask

    // ------------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------------

    // Empty list queries, the extremes of id and grade, insert at the head,
    // after a list node, after a slot that is not on the list, after the very
    // slot being taken, and the unused op code.
    task automatic test_directed_cases();
        send_noise_op(OP_WALK);
        send_noise_op(OP_FIND);
        send_noise_op(OP_UNUSED);
        send_op(OP_INSERT, 24'h000000, 10'd0,    1'b0, 4'd15);
        send_op(OP_INSERT, 24'hFFFFFF, 10'd1023, 1'b0, 4'd0);
        send_op(OP_INSERT, 24'h123456, 10'd0,    1'b1, 4'd0);
        send_op(OP_INSERT, 24'hABCDEF, 10'd1023, 1'b1, 4'd2);
        send_noise_op(OP_WALK);
        send_noise_op(OP_FIND);
        // Slot 9 holds nothing yet, so the new node hangs off the free chain.
        send_op(OP_INSERT, 24'h5A5A5A, 10'd341,  1'b1, 4'd9);
        // The target equals the slot about to be taken, so it links to itself.
        send_op(OP_INSERT, 24'hA5A5A5, 10'd682,  1'b1, free_ptr[SLOT_W-1:0]);
        send_noise_op(OP_WALK);
        send_noise_op(OP_FIND);
        send_op(OP_UNUSED, 24'hFFFFFF, 10'd1023, 1'b1, 4'd15);
    endtask

    // The receiver stalls for a long stretch while the sender keeps offering
    // walks and inserts, so the block backs up and drops s_tready. Inserts
    // go on until the pool is exhausted, then a couple more hit the full case.
    task automatic test_fill_under_backpressure();
        int extra;
        rx_hold_request = HOLD_CYCLES;
        send_noise_op(OP_WALK);
        send_noise_op(OP_FIND);
        while (free_ptr < NODES)
        begin
            send_random_insert();
            if ($urandom_range(0, 3) == 0)
                send_noise_op(OP_WALK);
        end
        for (extra = 0; extra < 2; extra++)
            send_random_insert();
        send_noise_op(OP_WALK);
        send_noise_op(OP_FIND);
    endtask

    // Random mix of all operations up to the item budget.
    task automatic test_random_mix();
        int pick;
        while (valid_ops_sent < ITEM_TOTAL)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 35)
                send_random_insert();
            else if (pick < 65)
                send_noise_op(OP_WALK);
            else if (pick < 95)
                send_noise_op(OP_FIND);
            else
                send_noise_op(OP_UNUSED);
        end
    endtask

    // ------------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------------

    initial
    begin
        rst_n    <= 1'b0;
        s_tvalid <= 1'b0;
        s_tdata  <= '0;
        s_tuser  <= OP_INSERT;
        pool_reset();
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;

        test_directed_cases();
        test_fill_under_backpressure();
        test_random_mix();
        s_tvalid <= 1'b0;

        // Let every owed result arrive, then watch a while for strays.
        while (awaited_results.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (mismatch_count == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

    initial
    begin : watchdog
        #(TIMEOUT_NS);
        $display("Simulation FAILED");
        $finish;
    end

endmodule
